@@ sv/pcd_pkg.sv @@
// Package: shared types and codes for the page cache directory.
package pcd_pkg;
	localparam int NUM_SLOTS = 32;

	typedef enum logic [1:0] {
		MODE_LOOKUP  = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_EVICT   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_OUT_OF_PAGES = 3'd1,
		ST_BUSY         = 3'd2,
		ST_UNDERFLOW    = 3'd3,
		ST_SATURATED    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_OUT  = 2'd2
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;
endpackage

@@ sv/pcd_ctrl.sv @@
// Controller: sequences capture, execute and result delivery.
module pcd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output pcd_pkg::cmd_t cmd
);
	import pcd_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d = S_EXEC;
					end else state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ sv/pcd_datapath.sv @@
// Datapath: tag match, reference counts, LRU list and result register.
module pcd_datapath #(
	parameter int REF_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pcd_pkg::cmd_t cmd,
	input  logic [1:0]    mode,
	input  logic [31:0]   block_number,
	input  logic [4:0]    slot_index,
	output logic [4:0]    page_slot,
	output logic          hit,
	output logic          victim_was_valid,
	output logic [31:0]   victim_block,
	output logic [2:0]    status
);
	import pcd_pkg::*;
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [REF_BITS-1:0] REF_MAX = '1;

	logic [31:0] tag_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q, inl_q;
	logic [REF_BITS-1:0] refs_q [NUM_SLOTS];
	logic [SW-1:0] next_q [NUM_SLOTS];
	logic [SW-1:0] prev_q [NUM_SLOTS];
	logic [SW-1:0] head_q, tail_q;
	logic nonempty_q;

	logic [1:0] mode_q;
	logic [31:0] blk_q;
	logic [4:0] sidx_q;
	logic [NUM_SLOTS-1:0] match_q;

	// match vector, registered at load against current tags
	logic [NUM_SLOTS-1:0] match_d;
	always_comb
		for (int i = 0; i < NUM_SLOTS; i++)
			match_d[i] = valid_q[i] && (tag_q[i] == block_number);

	logic found;
	logic [SW-1:0] fidx;
	always_comb begin
		found = 1'b0;
		fidx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--)
			if (match_q[i]) begin
				found = 1'b1;
				fidx = SW'(i);
			end
	end

	logic sidx_ok;
	logic [SW-1:0] sidx;
	assign sidx_ok = ({27'd0, sidx_q} < 32'(NUM_SLOTS));
	assign sidx = SW'(sidx_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			blk_q <= block_number;
			sidx_q <= slot_index;
			match_q <= match_d;
		end
	end

	// one list operation per item: unlink slot u, then optionally append/prepend
	logic do_unlink, do_app, do_pre, do_tag, do_inval, do_inc, do_dec;
	logic [SW-1:0] u;
	logic [4:0] r_slot;
	logic r_hit, r_vv;
	logic [31:0] r_vb;
	status_t r_st;

	always_comb begin
		do_unlink = 0; do_app = 0; do_pre = 0; do_tag = 0;
		do_inval = 0; do_inc = 0; do_dec = 0;
		u = fidx;
		r_slot = '0; r_hit = 0; r_vv = 0; r_vb = '0; r_st = ST_OK;
		case (mode_t'(mode_q))
			MODE_LOOKUP: begin
				if (found) begin
					r_slot = 5'(fidx);
					r_hit = 1;
					if (refs_q[fidx] >= REF_MAX) r_st = ST_SATURATED;
					else begin
						do_unlink = 1;
						do_inc = 1;
					end
				end else if (!nonempty_q) r_st = ST_OUT_OF_PAGES;
				else begin
					u = head_q;
					do_unlink = 1;
					do_tag = 1;
					r_slot = 5'(head_q);
					r_vv = valid_q[head_q];
					r_vb = valid_q[head_q] ? tag_q[head_q] : '0;
				end
			end
			MODE_RELEASE: begin
				r_slot = sidx_q;
				u = sidx;
				if (!sidx_ok || refs_q[sidx] == '0) r_st = ST_UNDERFLOW;
				else begin
					do_dec = 1;
					do_app = (refs_q[sidx] == REF_BITS'(1));
				end
			end
			MODE_EVICT: begin
				if (found) begin
					r_slot = 5'(fidx);
					r_hit = 1;
					if (refs_q[fidx] != '0) r_st = ST_BUSY;
					else begin
						do_inval = 1;
						do_unlink = 1;
						do_pre = 1;
					end
				end
			end
			default: ;
		endcase
	end

	// list after unlink (combinational view of head/tail/nonempty)
	logic [SW-1:0] h1, t1;
	logic ne1, was_in;
	always_comb begin
		h1 = head_q; t1 = tail_q; ne1 = nonempty_q;
		was_in = inl_q[u];
		if (do_unlink && was_in) begin
			if (u == head_q && u == tail_q) ne1 = 0;
			else if (u == head_q) h1 = next_q[u];
			else if (u == tail_q) t1 = prev_q[u];
		end
	end
	logic mid;
	assign mid = do_unlink && was_in && (u != head_q) && (u != tail_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			inl_q <= '1;
			head_q <= '0;
			tail_q <= SW'(NUM_SLOTS - 1);
			nonempty_q <= 1'b1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				tag_q[i] <= '0;
				refs_q[i] <= '0;
				next_q[i] <= SW'((i + 1) % NUM_SLOTS);
				prev_q[i] <= SW'((i + NUM_SLOTS - 1) % NUM_SLOTS);
			end
		end else if (cmd.exec) begin
			if (mid) begin
				next_q[prev_q[u]] <= next_q[u];
				prev_q[next_q[u]] <= prev_q[u];
			end
			if (do_unlink) inl_q[u] <= 1'b0;
			if (do_tag) begin
				tag_q[u] <= blk_q;
				valid_q[u] <= 1'b1;
				refs_q[u] <= REF_BITS'(1);
			end
			if (do_inc) refs_q[u] <= refs_q[u] + REF_BITS'(1);
			if (do_dec) refs_q[u] <= refs_q[u] - REF_BITS'(1);
			if (do_inval) valid_q[u] <= 1'b0;
			head_q <= h1; tail_q <= t1; nonempty_q <= ne1;
			if (do_app) begin
				inl_q[u] <= 1'b1;
				tail_q <= u;
				nonempty_q <= 1'b1;
				if (!ne1) head_q <= u;
				else begin
					next_q[t1] <= u;
					prev_q[u] <= t1;
				end
			end
			if (do_pre) begin
				inl_q[u] <= 1'b1;
				head_q <= u;
				nonempty_q <= 1'b1;
				if (!ne1) tail_q <= u;
				else begin
					prev_q[h1] <= u;
					next_q[u] <= h1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			page_slot <= r_slot;
			hit <= r_hit;
			victim_was_valid <= r_vv;
			victim_block <= r_vb;
			status <= r_st;
		end
	end
endmodule

@@ sv/page_cache_directory_lru_top.sv @@
// Top level: page cache directory with refcounted LRU free list.
// Flow: capture at accept, then execute, then hold the result until it is taken;
// the tag match is registered at accept and the list relink and result register
// update in the execute cycle.
// A new request is taken in the same cycle the prior result is taken.
// Reset (arst_n low, asynchronous): all slots invalid, counts zero, every slot in
// the free list in index order, head slot 0, no result pending.
module page_cache_directory_lru_top #(
	parameter int REF_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] block_number,
	input  logic [4:0]  slot_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  page_slot,
	output logic        hit,
	output logic        victim_was_valid,
	output logic [31:0] victim_block,
	output logic [2:0]  status
);
	import pcd_pkg::*;
	cmd_t cmd;

	// sequence each request: capture, execute, hold result until taken
	pcd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
	);

	// directory state and result register
	pcd_datapath #(.REF_BITS(REF_BITS)) u_dp (
		.clk, .arst_n, .cmd, .mode, .block_number, .slot_index,
		.page_slot, .hit, .victim_was_valid, .victim_block, .status
	);
endmodule

@@ sv/pcd_checker.sv @@
// Checker: port-level properties of the page cache directory, with bind.
module pcd_sva (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       hit,
	input logic       victim_was_valid,
	input logic [2:0] status
);
	import pcd_pkg::*;
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped under stall");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid && !in_ready)
		else $error("request overlap");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("result missing");
	a_vv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && victim_was_valid |-> !hit && status == ST_OK)
		else $error("victim on hit");
endmodule

bind page_cache_directory_lru_top pcd_sva u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.hit, .victim_was_valid, .status
);

@@ test/pcd_checker.sv @@
// Checker: watches both channels, predicts directory results and compares them.
module pcd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] block_number,
	input  logic [4:0]  slot_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  page_slot,
	input  logic        hit,
	input  logic        victim_was_valid,
	input  logic [31:0] victim_block,
	input  logic [2:0]  status,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import pcd_pkg::*;

	localparam int SLOTS = 32;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [4:0]  page_slot;
		logic        hit;
		logic        victim_was_valid;
		logic [31:0] victim_block;
		status_t     status;
	} dir_result_t;

	logic [31:0] tags [SLOTS];
	logic        valid [SLOTS];
	logic [7:0]  refs [SLOTS];
	logic [4:0]  nxt [SLOTS];
	logic [4:0]  prv [SLOTS];
	logic        linked [SLOTS];
	logic [4:0]  head, tail;
	logic        nonempty;
	dir_result_t expected_q [$];

	function automatic int find_tag(logic [31:0] tag);
		for (int i = 0; i < SLOTS; i++)
			if (valid[i] && tags[i] == tag)
				return i;
		return SLOTS;
	endfunction

	function automatic void unlink(int s);
		if (!linked[s])
			return;
		if (s == head && s == tail)
			nonempty = 0;
		else if (s == head)
			head = nxt[s];
		else if (s == tail)
			tail = prv[s];
		else begin
			nxt[prv[s]] = nxt[s];
			prv[nxt[s]] = prv[s];
		end
		linked[s] = 0;
	endfunction

	function automatic void link_at(int s, bit at_head);
		if (!nonempty) begin
			head = 5'(s);
			tail = 5'(s);
			nonempty = 1;
		end else if (at_head) begin
			prv[head] = 5'(s);
			nxt[s] = head;
			head = 5'(s);
		end else begin
			nxt[tail] = 5'(s);
			prv[s] = tail;
			tail = 5'(s);
		end
		linked[s] = 1;
	endfunction

	function automatic dir_result_t apply_request(mode_t m, logic [31:0] blk, logic [4:0] idx);
		dir_result_t r;
		int s;
		r = '0;
		r.status = ST_OK;
		case (m)
			MODE_LOOKUP: begin
				s = find_tag(blk);
				if (s < SLOTS) begin
					r.page_slot = 5'(s);
					r.hit = 1;
					if (refs[s] >= COUNT_MAX)
						r.status = ST_SATURATED;
					else begin
						unlink(s);
						refs[s]++;
					end
				end else if (!nonempty)
					r.status = ST_OUT_OF_PAGES;
				else begin
					s = head;
					unlink(s);
					if (valid[s]) begin
						r.victim_was_valid = 1;
						r.victim_block = tags[s];
					end
					tags[s] = blk;
					valid[s] = 1;
					refs[s] = 1;
					r.page_slot = 5'(s);
				end
			end
			MODE_RELEASE: begin
				r.page_slot = idx;
				if (refs[idx] == 0)
					r.status = ST_UNDERFLOW;
				else begin
					refs[idx]--;
					if (refs[idx] == 0)
						link_at(idx, 0);
				end
			end
			MODE_EVICT: begin
				s = find_tag(blk);
				if (s < SLOTS) begin
					r.page_slot = 5'(s);
					r.hit = 1;
					if (refs[s] > 0)
						r.status = ST_BUSY;
					else begin
						valid[s] = 0;
						unlink(s);
						link_at(s, 1);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dir_result_t exp_r, got;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				tags[i] = '0;
				valid[i] = 0;
				refs[i] = '0;
				nxt[i] = 5'((i + 1) % SLOTS);
				prv[i] = 5'((i + SLOTS - 1) % SLOTS);
				linked[i] = 1;
			end
			head = 0;
			tail = 5'(SLOTS - 1);
			nonempty = 1;
			expected_q.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{page_slot, hit, victim_was_valid, victim_block, status_t'(status)};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %p", got);
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", exp_r, got);
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(apply_request(mode_t'(mode), block_number, slot_index));
			pending_count = expected_q.size();
		end
	end
endmodule

@@ test/tb_page_cache_directory_lru_top.sv @@
// Testbench top: drives directory requests, stalls results and reports the verdict.
module tb_page_cache_directory_lru_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pcd_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  mode = MODE_LOOKUP;
	logic [31:0] block_number = '0;
	logic [4:0]  slot_index = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [4:0]  page_slot;
	logic        hit, victim_was_valid;
	logic [31:0] victim_block;
	logic [2:0]  status;
	int          fail_count, pending_count;
	bit          hold_off = 0;

	// Small pool of block numbers so lookups hit, plus the field extremes.
	logic [31:0] block_pool [48];

	page_cache_directory_lru_top dut (.*);

	pcd_checker checker_i (.*);

	initial forever #4 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one request and hold it until accepted.
	task automatic send_request(mode_t m, logic [31:0] blk, logic [4:0] idx);
		in_valid <= 1;
		mode <= m;
		block_number <= blk;
		slot_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle_input(int n);
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Result side: random stalls, and a long hold-off when asked.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 0;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
		end
	end

	initial begin
		int r, burst, wait_cycles;
		logic [31:0] blk;
		for (int i = 0; i < 48; i++)
			block_pool[i] = $urandom();
		block_pool[0] = 32'h0000_0000;
		block_pool[1] = 32'hFFFF_FFFF;
		block_pool[2] = 32'hAAAA_AAAA;
		block_pool[3] = 32'h5555_5555;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every operation and each corner.
		send_request(MODE_EVICT, 32'h0, 5'd0);       // evict of uncached block
		send_request(MODE_RELEASE, 32'h0, 5'd31);    // release underflow
		send_request(MODE_LOOKUP, 32'h0, 5'd0);      // miss on block zero
		send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 5'd31);
		send_request(MODE_LOOKUP, 32'h0, 5'd0);      // hit
		send_request(MODE_EVICT, 32'hFFFF_FFFF, 5'd0); // busy
		send_request(MODE_RELEASE, 32'h0, 5'd1);     // release slot 1 to zero
		send_request(MODE_EVICT, 32'hFFFF_FFFF, 5'd0); // evict to list head
		send_request(MODE_NONE, 32'h1234_5678, 5'd17);
		send_request(MODE_RELEASE, 32'h0, 5'd0);
		send_request(MODE_RELEASE, 32'h0, 5'd0);
		send_request(MODE_RELEASE, 32'h0, 5'd0);     // underflow after release
		// Exhaust the free list, then overflow it.
		for (int i = 0; i < 33; i++)
			send_request(MODE_LOOKUP, 32'h8000_0000 + i, 5'd0);
		// Saturate a count.
		for (int i = 0; i < 256; i++)
			send_request(MODE_LOOKUP, 32'h8000_0005, 5'd0);
		// Release every slot twice, then release slot 5 many more times.
		for (int i = 0; i < 32; i++)
			for (int k = 0; k < 2; k++)
				send_request(MODE_RELEASE, 32'h0, 5'(i));
		for (int i = 0; i < 260; i++)
			send_request(MODE_RELEASE, 32'h0, 5'd5);

		// Random: lookups, releases, evicts and no-ops over a small pool with random noise.
		for (int n = 0; n < 475; n++) begin
			if (n == 200)
				hold_off = 1;
			r = $urandom_range(0, 99);
			blk = ($urandom_range(0, 9) == 0) ? $urandom() : block_pool[$urandom_range(0, 47)];
			if (r < 45)
				send_request(MODE_LOOKUP, blk, 5'($urandom()));
			else if (r < 80)
				send_request(MODE_RELEASE, blk, 5'($urandom()));
			else if (r < 96)
				send_request(MODE_EVICT, blk, 5'($urandom()));
			else
				send_request(MODE_NONE, $urandom(), 5'($urandom()));
			// Leave back-to-back stretches without gaps.
			burst = (n / 100) % 3;
			if (burst != 0)
				idle_input(pick_gap());
		end
		in_valid <= 0;

		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ filelist.f @@
sv/pcd_pkg.sv
sv/pcd_ctrl.sv
sv/pcd_datapath.sv
sv/page_cache_directory_lru_top.sv
sv/pcd_checker.sv
test/pcd_checker.sv
test/tb_page_cache_directory_lru_top.sv
